### rtl/idl_pkg.sv
`default_nettype none

package idl_pkg;

  // tap delay field, unsigned Q12.F
  localparam int unsigned TAP_W = 22;

  // operand selected for the shared multiplier
  typedef enum logic [1:0] {
    MUL_C0 = 2'b00,
    MUL_C1 = 2'b01,
    MUL_C2 = 2'b10
  } mul_op_e;

  // sequencer controls for the interpolation datapath
  typedef struct packed {
    logic    shift;  // shift in a returned sample
    logic    coef;   // load the doubled coefficients
    logic    mul;    // run one Horner multiply
    mul_op_e op;     // which Horner step
    logic    fin;    // final round, add and saturate
  } interp_ctrl_t;

endpackage

`default_nettype wire

### rtl/idl_store.sv
`default_nettype none

module idl_store #(
  parameter int unsigned DEPTH       = 4096,
  parameter int unsigned SAMPLE_BITS = 24,
  localparam int unsigned AW         = $clog2(DEPTH)
) (
  input  wire logic                          clk_i,
  input  wire logic                          wr_en_i,
  input  wire logic [AW-1:0]                 wr_addr_i,
  input  wire logic [SAMPLE_BITS-1:0]        wr_left_i,
  input  wire logic [SAMPLE_BITS-1:0]        wr_right_i,
  input  wire logic                          rd_en_i,
  input  wire logic [AW-1:0]                 rd_addr_i,
  input  wire logic                          rd_chan_i,
  output logic signed [SAMPLE_BITS-1:0]      rd_data_o
);

  logic [SAMPLE_BITS-1:0] mem_l [DEPTH];
  logic [SAMPLE_BITS-1:0] mem_r [DEPTH];
  logic [SAMPLE_BITS-1:0] rd_l_q;
  logic [SAMPLE_BITS-1:0] rd_r_q;
  logic                   chan_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_l[wr_addr_i] <= wr_left_i;
      mem_r[wr_addr_i] <= wr_right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_l_q <= mem_l[rd_addr_i];
      rd_r_q <= mem_r[rd_addr_i];
      chan_q <= rd_chan_i;
    end
  end

  assign rd_data_o = chan_q ? $signed(rd_r_q) : $signed(rd_l_q);

endmodule

`default_nettype wire

### rtl/idl_interp.sv
`default_nettype none

module idl_interp #(
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned FRAC_BITS   = 10
) (
  input  wire logic                          clk_i,
  input  wire idl_pkg::interp_ctrl_t         ctrl_i,
  input  wire logic signed [SAMPLE_BITS-1:0] rd_data_i,
  input  wire logic [FRAC_BITS-1:0]          frac_i,
  output logic signed [SAMPLE_BITS-1:0]      result_o
);

  localparam int unsigned ACC_W  = SAMPLE_BITS + 6;
  localparam int unsigned PROD_W = ACC_W + FRAC_BITS + 1;
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0]  SAT_HI =
    ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0]  SAT_LO = -SAT_HI - ACC_W'(1);

  logic signed [SAMPLE_BITS-1:0] y0_q, y1_q, y2_q, y3_q;
  logic signed [ACC_W-1:0]       c0_q, c1_q, c2_q;
  logic signed [ACC_W-1:0]       c0_d, c1_d, c2_d;
  logic signed [ACC_W-1:0]       e0, e1, e2, e3, d12;
  logic signed [PROD_W-1:0]      prod_q, prod_d, rsum, rsh;
  logic signed [ACC_W-1:0]       acc, op_a, r1, total;
  logic signed [FRAC_BITS:0]     fs;
  logic signed [SAMPLE_BITS-1:0] res_q, res_d;

  assign e0  = ACC_W'(y0_q);
  assign e1  = ACC_W'(y1_q);
  assign e2  = ACC_W'(y2_q);
  assign e3  = ACC_W'(y3_q);
  assign d12 = e1 - e2;

  // doubled Catmull-Rom coefficients, exact in integers
  assign c0_d = e3 - e0 + d12 + (d12 <<< 1);
  assign c1_d = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
  assign c2_d = e2 - e0;

  // round to nearest, ties up: floor((p + half) / 2^F)
  assign rsum = prod_q + HALF;
  assign rsh  = rsum >>> FRAC_BITS;
  assign acc  = rsh[ACC_W-1:0];

  always_comb begin
    case (ctrl_i.op)
      idl_pkg::MUL_C0: op_a = c0_q;
      idl_pkg::MUL_C1: op_a = acc + c1_q;
      idl_pkg::MUL_C2: op_a = acc + c2_q;
      default:         op_a = c0_q;
    endcase
  end

  assign fs     = $signed({1'b0, frac_i});
  assign prod_d = PROD_W'(op_a) * PROD_W'(fs);

  assign r1    = (acc + ACC_W'(1)) >>> 1;
  assign total = e1 + r1;

  always_comb begin
    if (total > SAT_HI) begin
      res_d = SAT_HI[SAMPLE_BITS-1:0];
    end else if (total < SAT_LO) begin
      res_d = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      res_d = total[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      y0_q <= y1_q;
      y1_q <= y2_q;
      y2_q <= y3_q;
      y3_q <= rd_data_i;
    end
    if (ctrl_i.coef) begin
      c0_q <= c0_d;
      c1_q <= c1_d;
      c2_q <= c2_d;
    end
    if (ctrl_i.mul) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.fin) begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

endmodule

`default_nettype wire

### rtl/interpolated_delay_line.sv
// Tap read steps: position, four reads on one memory port, last read data,
// coefficients, three Horner multiplies, round, hand-off. A sample-pair write
// goes straight to hand-off. One beat in flight: no new beat is taken until
// the current one is handed off, which waits while the output register is stalled.
// Reset clears control at once; a clearing pass then zeroes both
// channel memories before the first input beat is taken.
`default_nettype none

module interpolated_delay_line #(
  parameter int unsigned DEPTH       = 4096,
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned FRAC_BITS   = 10
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          action_i,
  input  wire logic                          channel_i,
  input  wire logic [idl_pkg::TAP_W-1:0]     tap_delay_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_left_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_right_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]      tap_value_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned QW = AW + FRAC_BITS;      // position in Q.F
  localparam int unsigned PW = QW + 1;              // with borrow
  localparam int unsigned DW = (idl_pkg::TAP_W > QW) ? idl_pkg::TAP_W : QW;
  localparam logic [DW-1:0]   DMIN   = DW'(2) << FRAC_BITS;
  localparam logic [DW-1:0]   DMAX   = DW'(DEPTH - 3) << FRAC_BITS;
  localparam logic [PW-1:0]   SPAN   = PW'(DEPTH) << FRAC_BITS;
  localparam logic [AW-1:0]   LAST   = AW'(DEPTH - 1);
  localparam logic [AW:0]     DEPTH_W = (AW + 1)'(DEPTH);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_POS   = 11'b000_0000_0100,
    S_READ  = 11'b000_0000_1000,
    S_FETCH = 11'b000_0001_0000,
    S_COEF  = 11'b000_0010_0000,
    S_MUL0  = 11'b000_0100_0000,
    S_MUL1  = 11'b000_1000_0000,
    S_MUL2  = 11'b001_0000_0000,
    S_FIN   = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_e;

  state_e                   state_q, state_d;
  logic [AW-1:0]            wp_q;
  logic [AW-1:0]            clr_q;
  logic [AW-1:0]            rd_addr_q, rd_addr_d;
  logic [1:0]               cnt_q;
  logic                     rd_vld_q;
  logic                     is_wr_q;
  logic                     chan_q;
  logic [QW-1:0]            dly_q;
  logic [FRAC_BITS-1:0]     frac_q;
  logic                     out_valid_q;
  logic [SAMPLE_BITS-1:0]   out_data_q;

  logic                     in_acc;
  logic                     out_free;
  logic [DW-1:0]            dext, dclamp;
  logic [PW-1:0]            diff, pos;
  logic [AW-1:0]            idx, idx_prev;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [SAMPLE_BITS-1:0]   wr_left, wr_right;
  logic                     rd_en;
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic signed [SAMPLE_BITS-1:0] interp_res;
  idl_pkg::interp_ctrl_t    ctrl;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // clamp delay to 2..DEPTH-3 samples
  assign dext = DW'(tap_delay_i);
  always_comb begin
    if (dext < DMIN) begin
      dclamp = DMIN;
    end else if (dext > DMAX) begin
      dclamp = DMAX;
    end else begin
      dclamp = dext;
    end
  end

  // tap position behind the write pointer, wrapped once
  assign diff     = {1'b0, wp_q, {FRAC_BITS{1'b0}}} - {1'b0, dly_q};
  assign pos      = diff[PW-1] ? diff + SPAN : diff;
  assign idx      = pos[QW-1:FRAC_BITS];
  assign idx_prev = (idx == '0) ? LAST : idx - AW'(1);

  // memory port muxing: clearing pass or sample-pair write
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = wp_q;
    wr_left  = sample_left_i;
    wr_right = sample_right_i;
    if (state_q == S_CLEAR) begin
      wr_en    = 1'b1;
      wr_addr  = clr_q;
      wr_left  = '0;
      wr_right = '0;
    end else if (in_acc && action_i) begin
      wr_en = 1'b1;
    end
  end

  assign rd_en     = (state_q == S_READ);
  assign rd_addr_d = (rd_addr_q == LAST) ? '0 : rd_addr_q + AW'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == LAST) state_d = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          state_d = action_i ? S_DONE : S_POS;
        end
      end
      S_POS:   state_d = S_READ;
      S_READ:  if (cnt_q == 2'd3) state_d = S_FETCH;
      S_FETCH: state_d = S_COEF;
      S_COEF:  state_d = S_MUL0;
      S_MUL0:  state_d = S_MUL1;
      S_MUL1:  state_d = S_MUL2;
      S_MUL2:  state_d = S_FIN;
      S_FIN:   state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl.shift = rd_vld_q;
    ctrl.coef  = (state_q == S_COEF);
    ctrl.mul   = (state_q == S_MUL0) || (state_q == S_MUL1) || (state_q == S_MUL2);
    ctrl.fin   = (state_q == S_FIN);
    case (state_q)
      S_MUL1:  ctrl.op = idl_pkg::MUL_C1;
      S_MUL2:  ctrl.op = idl_pkg::MUL_C2;
      default: ctrl.op = idl_pkg::MUL_C0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      wp_q        <= '0;
      clr_q       <= '0;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (in_acc && action_i) begin
        wp_q <= (wp_q == LAST) ? '0 : wp_q + AW'(1);
      end
      if (state_q == S_POS) begin
        cnt_q <= '0;
      end else if (rd_en) begin
        cnt_q <= cnt_q + 2'd1;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      is_wr_q <= action_i;
      chan_q  <= channel_i;
      dly_q   <= dclamp[QW-1:0];
    end
    if (state_q == S_POS) begin
      rd_addr_q <= idx_prev;
      frac_q    <= pos[FRAC_BITS-1:0];
    end else if (rd_en) begin
      rd_addr_q <= rd_addr_d;
    end
    if (state_q == S_DONE && out_free) begin
      out_data_q <= is_wr_q ? '0 : interp_res;
    end
  end

  idl_store #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_store (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_left_i  (wr_left),
    .wr_right_i (wr_right),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr_q),
    .rd_chan_i  (chan_q),
    .rd_data_o  (rd_data)
  );

  idl_interp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_interp (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .rd_data_i (rd_data),
    .frac_i    (frac_q),
    .result_o  (interp_res)
  );

  assign out_valid_o = out_valid_q;
  assign tap_value_o = out_data_q;

  // write pointer never leaves the buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, wp_q} < DEPTH_W)
    else $error("write pointer out of range");

  // a write beat advances the pointer by one, wrapping at the end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && action_i |=> (wp_q == (($past(wp_q) == LAST) ? '0 : $past(wp_q) + AW'(1))))
    else $error("write pointer did not advance");

  // returned read data only lands while the sample window is being filled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == S_READ || state_q == S_FETCH))
    else $error("stray memory read data");

  // a new result only comes out of the hand-off state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result presented outside hand-off");

endmodule

`default_nettype wire
